FILE: rtl/wsfr_pkg.sv
package wsfr_pkg;

  // Queue between the header parser and the output stage.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Event kinds carried on the result channel.
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_EMPTY = 1'b1;

  // One classified request waiting for the output stage.
  typedef struct packed {
    logic       kind;
    logic [7:0] raw;
    logic [7:0] key;
    logic [3:0] opcode;
    logic       fin;
    logic       done;
  } q_item_t;

endpackage

FILE: rtl/websocket_frame_receiver.sv
// Channel  | Ports        | Contents (lowest bit first)
// in_      | tvalid/tready| tdata[7:0] rx_byte
// out_     | tvalid/tready| tdata[7:0] payload_byte, [11:8] frame_opcode,
//          |              | [12] final_fragment, [15:13] zero; tuser event_kind;
//          |              | tlast frame_done
//
// One byte is accepted per clock while the four-entry queue has room.
// A result goes into the queue when its byte is accepted and is then loaded into the output register.
// The parser stalls only when the queue is full; the queue absorbs output stalls.
// Synchronous active-low reset returns the parser to the first header byte
// and empties the queue and output register.
module websocket_frame_receiver #(
  parameter int LENGTH_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // payload_byte, frame_opcode, final_fragment, pad
  output logic        out_tuser,  // event_kind
  output logic        out_tlast
);

  logic              q_full;
  logic              in_fire;
  logic              push_valid;
  wsfr_pkg::q_item_t push_item;
  logic              q_valid;
  logic              q_pop;
  wsfr_pkg::q_item_t q_item;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  // Front: header parsing and byte classification.
  wsfr_parser #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .rx_byte   (in_tdata),
    .push_valid(push_valid),
    .push_item (push_item)
  );

  // Short queue between the parser and the output stage.
  wsfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_item)
  );

  // Back: unmasking and output register.
  wsfr_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

FILE: rtl/wsfr_parser.sv
module wsfr_parser #(
  parameter int LENGTH_WIDTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [7:0]        rx_byte,
  output logic              push_valid,
  output wsfr_pkg::q_item_t push_item
);

  // Parse phases.
  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXT16   = 3'd2;
  localparam logic [2:0] PH_EXT64   = 3'd3;
  localparam logic [2:0] PH_KEY     = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [2:0] EXT16_LAST = 3'd1;
  localparam logic [2:0] EXT64_LAST = 3'd7;
  localparam logic [2:0] KEY_LAST   = 3'd3;

  logic [2:0]              phase_r, phase_nxt;
  logic [2:0]              cnt_r, cnt_nxt;
  logic [3:0]              opcode_r, opcode_nxt;
  logic                    fin_r, fin_nxt;
  logic                    masked_r, masked_nxt;
  logic [31:0]             key_r, key_nxt;
  logic [LENGTH_WIDTH-1:0] len_r, len_nxt;
  logic [1:0]              idx_r, idx_nxt;

  logic [LENGTH_WIDTH-1:0] len_shift;
  logic [LENGTH_WIDTH-1:0] len_short;
  logic [6:0]              len7;
  logic [7:0]              key_byte;
  logic                    ext_last;

  assign len_shift = {len_r[LENGTH_WIDTH-9:0], rx_byte};
  assign len7      = rx_byte[6:0];
  assign len_short = {{(LENGTH_WIDTH-7){1'b0}}, len7};
  assign key_byte  = key_r[{~idx_r, 3'b000} +: 8];
  assign ext_last  = (phase_r == PH_EXT16) ? (cnt_r == EXT16_LAST) : (cnt_r == EXT64_LAST);

  // Header decode and payload classification, one byte per accepted request.
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    opcode_nxt = opcode_r;
    fin_nxt    = fin_r;
    masked_nxt = masked_r;
    key_nxt    = key_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    push_valid = 1'b0;
    push_item.kind   = wsfr_pkg::KIND_EMPTY;
    push_item.raw    = 8'd0;
    push_item.key    = 8'd0;
    push_item.opcode = opcode_r;
    push_item.fin    = fin_r;
    push_item.done   = 1'b1;
    if (in_fire) begin
      case (phase_r)
        PH_HDR1: begin
          masked_nxt = rx_byte[7];
          key_nxt    = 32'd0;
          cnt_nxt    = 3'd0;
          idx_nxt    = 2'd0;
          if (len7 == LEN7_EXT16) begin
            len_nxt   = '0;
            phase_nxt = PH_EXT16;
          end else if (len7 == LEN7_EXT64) begin
            len_nxt   = '0;
            phase_nxt = PH_EXT64;
          end else begin
            len_nxt = len_short;
            if (rx_byte[7]) begin
              phase_nxt = PH_KEY;
            end else if (len7 == 7'd0) begin
              push_valid = 1'b1;
              phase_nxt  = PH_HDR0;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_EXT16, PH_EXT64: begin
          len_nxt = len_shift;
          cnt_nxt = cnt_r + 3'd1;
          if (ext_last) begin
            cnt_nxt = 3'd0;
            if (masked_r) begin
              phase_nxt = PH_KEY;
            end else if (len_shift == '0) begin
              push_valid = 1'b1;
              phase_nxt  = PH_HDR0;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_KEY: begin
          key_nxt = {key_r[23:0], rx_byte};
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_r == KEY_LAST) begin
            cnt_nxt = 3'd0;
            idx_nxt = 2'd0;
            if (len_r == '0) begin
              push_valid = 1'b1;
              phase_nxt  = PH_HDR0;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          // The length register counts down the bytes still to come.
          push_valid     = 1'b1;
          push_item.kind = wsfr_pkg::KIND_BYTE;
          push_item.raw  = rx_byte;
          push_item.key  = key_byte;
          push_item.done = (len_r == {{(LENGTH_WIDTH-1){1'b0}}, 1'b1});
          idx_nxt        = idx_r + 2'd1;
          len_nxt        = len_r - {{(LENGTH_WIDTH-1){1'b0}}, 1'b1};
          if (push_item.done) begin
            phase_nxt = PH_HDR0;
          end
        end
        default: begin
          fin_nxt    = rx_byte[7];
          opcode_nxt = rx_byte[3:0];
          phase_nxt  = PH_HDR1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      cnt_r    <= 3'd0;
      opcode_r <= 4'd0;
      fin_r    <= 1'b0;
      masked_r <= 1'b0;
      key_r    <= 32'd0;
      len_r    <= '0;
      idx_r    <= 2'd0;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      opcode_r <= opcode_nxt;
      fin_r    <= fin_nxt;
      masked_r <= masked_nxt;
      key_r    <= key_nxt;
      len_r    <= len_nxt;
      idx_r    <= idx_nxt;
    end
  end

endmodule

FILE: rtl/wsfr_queue.sv
module wsfr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  wsfr_pkg::q_item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output wsfr_pkg::q_item_t pop_item
);

  wsfr_pkg::q_item_t                 mem_r [wsfr_pkg::QDEPTH];
  logic [wsfr_pkg::QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [wsfr_pkg::QCNT_W-1:0]       count_r;
  logic                              push_fire, pop_fire;

  assign full      = (count_r == wsfr_pkg::QCNT_W'(wsfr_pkg::QDEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];
  assign push_fire = push_valid && !full;
  assign pop_fire  = pop && pop_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_r <= wr_ptr_r + wsfr_pkg::QPTR_W'(1);
      end
      if (pop_fire) begin
        rd_ptr_r <= rd_ptr_r + wsfr_pkg::QPTR_W'(1);
      end
      if (push_fire && !pop_fire) begin
        count_r <= count_r + wsfr_pkg::QCNT_W'(1);
      end else if (!push_fire && pop_fire) begin
        count_r <= count_r - wsfr_pkg::QCNT_W'(1);
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= wsfr_pkg::QCNT_W'(wsfr_pkg::QDEPTH))
    else $error("queue count exceeds depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push_fire && !pop_fire) |=> (count_r == $past(count_r) + wsfr_pkg::QCNT_W'(1)))
    else $error("queue count did not advance on push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0 && count_r != wsfr_pkg::QCNT_W'(wsfr_pkg::QDEPTH))
      |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with count");
`endif

endmodule

FILE: rtl/wsfr_emit.sv
module wsfr_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  wsfr_pkg::q_item_t q_item,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,
  output logic              out_tuser,
  output logic              out_tlast
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic [3:0] opcode_r;
  logic       fin_r;
  logic       kind_r;
  logic       done_r;
  logic       load;

  assign load  = q_valid && (!valid_r || out_tready);
  assign q_pop = load;

  // Unmask and register the next result.
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= q_item.raw ^ q_item.key;
      opcode_r <= q_item.opcode;
      fin_r    <= q_item.fin;
      kind_r   <= q_item.kind;
      done_r   <= q_item.done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {3'b000, fin_r, opcode_r, byte_r};
  assign out_tuser  = kind_r;
  assign out_tlast  = done_r;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

// Streaming deframer bench: framed requests go in byte by byte, and every
// payload byte and empty-frame event coming out is checked against a local model or a pinned row.
module tb_top;

  localparam int LEN_W = 64;
  localparam logic [63:0] LEN_MASK = (LEN_W >= 64) ? '1 : ((64'd1 << LEN_W) - 64'd1);
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam int RANDOM_BYTES = 500;
  localparam int DRAIN_LIMIT = 20000;
  localparam int DRAIN_TAIL = 12;
  localparam int MAX_PRINTED = 40;

  typedef enum logic [3:0] {
    OP_CONT   = 4'h0,
    OP_TEXT   = 4'h1,
    OP_BINARY = 4'h2,
    OP_CLOSE  = 4'h8,
    OP_PING   = 4'h9,
    OP_PONG   = 4'hA,
    OP_RSVD_F = 4'hF
  } ws_opcode_e;

  typedef enum logic [2:0] {
    P_FLAGS, P_LEN7, P_EXT16, P_EXT64, P_KEY, P_BODY
  } parse_phase_e;

  typedef enum logic [1:0] {
    RX_OPEN, RX_RANDOM, RX_QUARTER, RX_TRICKLE
  } rx_mode_e;

  // One event on the result channel.
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [3:0] opcode;
    logic       fin;
    logic       done;
  } ws_event_t;

  // One byte request; a pinned row carries its result written out by hand.
  typedef struct packed {
    logic [7:0] data;
    logic       pinned;
    ws_event_t  ev;
  } byte_req_t;

  localparam ws_event_t NO_EVENT = '0;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  websocket_frame_receiver #(.LENGTH_WIDTH(LEN_W)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("Timeout: results still outstanding");
    $display("Simulation FAILED");
    $finish;
  end

  ws_event_t    pending_events[$];
  int           error_count = 0;
  int           bytes_sent = 0;
  int           frames_sent = 0;
  int           byte_results = 0;
  int           empty_results = 0;
  int           burst_left = 0;

  // Deframer state mirrored on the bench side.
  parse_phase_e ws_phase = P_FLAGS;
  logic [3:0]   ws_hdr_cnt = '0;
  logic [3:0]   ws_opcode = '0;
  logic         ws_fin = 1'b0;
  logic         ws_masked = 1'b0;
  logic [31:0]  ws_key = '0;
  logic [63:0]  ws_len = '0;
  logic [63:0]  ws_body_cnt = '0;

  task automatic note_error(input string msg);
    if (error_count < MAX_PRINTED) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Header and key are complete: either open the payload or report an empty frame.
  function automatic bit open_payload(output ws_event_t ev);
    ev = NO_EVENT;
    ws_body_cnt = '0;
    if (ws_len == 64'd0) begin
      ev = {wsfr_pkg::KIND_EMPTY, 8'h00, ws_opcode, ws_fin, 1'b1};
      ws_phase = P_FLAGS;
      return 1'b1;
    end
    ws_phase = P_BODY;
    return 1'b0;
  endfunction

  // Length is complete: a masked frame still has its key to come.
  function automatic bit finish_length(output ws_event_t ev);
    ev = NO_EVENT;
    ws_len = ws_len & LEN_MASK;
    ws_hdr_cnt = '0;
    if (ws_masked) begin
      ws_phase = P_KEY;
      return 1'b0;
    end
    return open_payload(ev);
  endfunction

  // Advance the mirrored deframer by one byte; returns 1 when an event results.
  function automatic bit deframe_byte(input logic [7:0] b, output ws_event_t ev);
    logic [6:0] len7;
    logic [7:0] key_byte;
    logic       last;
    bit         got;
    got = 1'b0;
    ev = NO_EVENT;
    case (ws_phase)
      P_LEN7: begin
        ws_masked = b[7];
        len7 = b[6:0];
        ws_key = '0;
        ws_body_cnt = '0;
        ws_hdr_cnt = '0;
        if (len7 == LEN7_EXT16) begin
          ws_len = '0;
          ws_phase = P_EXT16;
        end else if (len7 == LEN7_EXT64) begin
          ws_len = '0;
          ws_phase = P_EXT64;
        end else begin
          ws_len = {57'd0, len7};
          got = finish_length(ev);
        end
      end
      P_EXT16, P_EXT64: begin
        ws_len = {ws_len[55:0], b};
        ws_hdr_cnt = ws_hdr_cnt + 4'd1;
        if (ws_hdr_cnt >= ((ws_phase == P_EXT16) ? 4'd2 : 4'd8)) got = finish_length(ev);
      end
      P_KEY: begin
        ws_key = {ws_key[23:0], b};
        ws_hdr_cnt = ws_hdr_cnt + 4'd1;
        if (ws_hdr_cnt >= 4'd4) begin
          ws_hdr_cnt = '0;
          got = open_payload(ev);
        end
      end
      P_BODY: begin
        key_byte = ws_key[8 * (3 - ws_body_cnt[1:0]) +: 8];
        ws_body_cnt = ws_body_cnt + 64'd1;
        last = (ws_body_cnt >= ws_len);
        ev = {wsfr_pkg::KIND_BYTE, b ^ key_byte, ws_opcode, ws_fin, last};
        got = 1'b1;
        if (last) ws_phase = P_FLAGS;
      end
      default: begin
        ws_fin = b[7];
        ws_opcode = b[3:0];
        ws_phase = P_LEN7;
      end
    endcase
    return got;
  endfunction

  function automatic byte_req_t plain(input logic [7:0] b);
    return {b, 1'b0, NO_EVENT};
  endfunction

  // Offer one request, wait for the handshake, then log what it should produce.
  task automatic send_byte(input byte_req_t r);
    ws_event_t ev;
    in_tvalid <= 1'b1;
    in_tdata <= r.data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (deframe_byte(r.data, ev)) begin
      pending_events.push_back(r.pinned ? r.ev : ev);
    end else if (r.pinned) begin
      note_error($sformatf("pinned row %h gives no event in the local model", r.data));
    end
    bytes_sent++;
    // Sender idles in bursts; sometimes long stretches run without a gap.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) < 3) ? $urandom_range(40, 120) : $urandom_range(0, 12);
    end
  endtask

  // Hold the sender until every expected event has been seen.
  task automatic hold_until_drained();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending_events.size() != 0 && waited < DRAIN_LIMIT);
  endtask

  // Build and send one well-formed frame with random header and payload.
  // An open-ended frame carries a huge 64-bit length and is never finished.
  task automatic send_random_frame(input bit open_ended);
    byte_req_t  frame_bytes[$];
    logic [3:0] opc;
    logic [2:0] rsv;
    logic       fin;
    logic       masked;
    logic [31:0] key;
    logic [63:0] len;
    int         pick;
    int         len_form;
    int         body_count;
    opc = 4'($urandom_range(0, 15));
    rsv = 3'($urandom_range(0, 7));
    fin = 1'($urandom_range(0, 1));
    masked = ($urandom_range(0, 3) != 0);
    key = $urandom;
    pick = $urandom_range(0, 99);
    len_form = 0;
    if (open_ended) begin
      len = {1'b1, 31'($urandom), 32'($urandom)};
      len_form = 2;
    end else if (pick < 10) begin
      len = 64'd0;
    end else if (pick < 55) begin
      len = 64'($urandom_range(1, 8));
    end else if (pick < 68) begin
      len = 64'($urandom_range(9, 40));
    end else if (pick < 71) begin
      len = 64'($urandom_range(100, 125));
    end else if (pick < 83) begin
      len = 64'(($urandom_range(0, 19) == 0) ? $urandom_range(256, 296)
                                             : $urandom_range(0, 24));
      len_form = 1;
    end else begin
      len = 64'($urandom_range(0, 24));
      len_form = 2;
    end
    body_count = open_ended ? $urandom_range(3, 6) : int'(len);

    frame_bytes.push_back(plain({fin, rsv, opc}));
    case (len_form)
      0: frame_bytes.push_back(plain({masked, len[6:0]}));
      1: begin
        frame_bytes.push_back(plain({masked, LEN7_EXT16}));
        frame_bytes.push_back(plain(len[15:8]));
        frame_bytes.push_back(plain(len[7:0]));
      end
      default: begin
        frame_bytes.push_back(plain({masked, LEN7_EXT64}));
        for (int i = 7; i >= 0; i--) frame_bytes.push_back(plain(len[8 * i +: 8]));
      end
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) frame_bytes.push_back(plain(key[8 * i +: 8]));
    end
    for (int i = 0; i < body_count; i++) frame_bytes.push_back(plain(8'($urandom_range(0, 255))));

    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
    frames_sent++;
  endtask

  // Receiver: stall pattern is redrawn whenever the low six bits of rx_cycle are zero; results are checked in order.
  logic [15:0] rx_cycle = '0;
  rx_mode_e    rx_mode = RX_OPEN;

  always @(posedge clk) begin : result_check
    ws_event_t want;
    rx_cycle <= rx_cycle + 16'd1;
    if (rx_cycle[5:0] == 6'd0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:    out_tready <= 1'b1;
      RX_RANDOM:  out_tready <= 1'($urandom_range(0, 1));
      RX_QUARTER: out_tready <= (rx_cycle[1:0] == 2'd3);
      default:    out_tready <= (rx_cycle[3:0] == 4'd0);
    endcase

    if (rst_n && out_tvalid && out_tready) begin
      if (out_tuser == wsfr_pkg::KIND_EMPTY) empty_results++;
      else byte_results++;
      if (pending_events.size() == 0) begin
        note_error($sformatf("unexpected result tdata=%h tuser=%b tlast=%b",
                             out_tdata, out_tuser, out_tlast));
      end else begin
        want = pending_events.pop_front();
        if (out_tuser !== want.kind)
          note_error($sformatf("event_kind %b, expected %b", out_tuser, want.kind));
        if (out_tdata[7:0] !== want.data)
          note_error($sformatf("payload_byte %h, expected %h", out_tdata[7:0], want.data));
        if (out_tdata[11:8] !== want.opcode)
          note_error($sformatf("frame_opcode %h, expected %h", out_tdata[11:8], want.opcode));
        if (out_tdata[12] !== want.fin)
          note_error($sformatf("final_fragment %b, expected %b", out_tdata[12], want.fin));
        if (out_tlast !== want.done)
          note_error($sformatf("frame_done %b, expected %b", out_tlast, want.done));
        if (out_tdata[15:13] !== 3'b000)
          note_error($sformatf("tdata padding %b is not zero", out_tdata[15:13]));
      end
    end
  end

  // Main sequence: reset, directed frames, random frames, drain and verdict.
  initial begin : main_seq
    byte_req_t directed[$];

    // Ping with no payload.
    directed.push_back(plain({1'b1, 3'b000, OP_PING}));
    directed.push_back({{1'b0, 7'd0}, 1'b1,
                        {wsfr_pkg::KIND_EMPTY, 8'h00, OP_PING, 1'b1, 1'b1}});
    // Masked one-byte binary fragment, all reserved bits set; FF xor FF gives zero.
    directed.push_back(plain({1'b0, 3'b111, OP_BINARY}));
    directed.push_back(plain({1'b1, 7'd1}));
    directed.push_back(plain(8'hFF));
    directed.push_back(plain(8'h00));
    directed.push_back(plain(8'hAA));
    directed.push_back(plain(8'h55));
    directed.push_back({8'hFF, 1'b1, {wsfr_pkg::KIND_BYTE, 8'h00, OP_BINARY, 1'b0, 1'b1}});
    // Non-minimal 16-bit length of zero.
    directed.push_back(plain({1'b1, 3'b101, OP_PONG}));
    directed.push_back(plain({1'b0, LEN7_EXT16}));
    directed.push_back(plain(8'h00));
    directed.push_back({8'h00, 1'b1, {wsfr_pkg::KIND_EMPTY, 8'h00, OP_PONG, 1'b1, 1'b1}});
    // Reserved opcode with a 64-bit length of zero.
    directed.push_back(plain({1'b1, 3'b010, OP_RSVD_F}));
    directed.push_back(plain({1'b0, LEN7_EXT64}));
    for (int i = 0; i < 7; i++) directed.push_back(plain(8'h00));
    directed.push_back({8'h00, 1'b1, {wsfr_pkg::KIND_EMPTY, 8'h00, OP_RSVD_F, 1'b1, 1'b1}});
    // Unmasked two-byte text fragment with extreme payload values.
    directed.push_back(plain({1'b0, 3'b000, OP_TEXT}));
    directed.push_back(plain({1'b0, 7'd2}));
    directed.push_back(plain(8'h00));
    directed.push_back(plain(8'hFF));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_byte(directed[i]);
    frames_sent += 5;
    hold_until_drained();

    // Random frames, with the occasional full pause until the output catches up.
    while (bytes_sent < directed.size() + RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0) hold_until_drained();
      send_random_frame(1'b0);
    end
    send_random_frame(1'b1);

    hold_until_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    while (pending_events.size() != 0) begin
      note_error($sformatf("expected event never arrived: %p", pending_events.pop_front()));
    end

    $display("Sent %0d frames in %0d bytes; checked %0d payload bytes and %0d empty frames.",
             frames_sent, bytes_sent, byte_results, empty_results);
    $display("Mismatches: %0d", error_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
